/* src/rc5_pkg.sv */
// ============================================================================
// RC5 package
// Word width, table sizes, schedule constants and the shared enum types.
// ============================================================================
package rc5_pkg;

    localparam int WORD_W      = 32;
    localparam int ROT_W       = $clog2(WORD_W);
    localparam int ROUNDS      = 12;
    localparam int TABLE_WORDS = 2 * ROUNDS + 2;
    localparam int MIX_STEPS   = 3 * TABLE_WORDS;
    localparam int IDX_W       = $clog2(TABLE_WORDS);
    localparam int STEP_W      = $clog2(MIX_STEPS);
    localparam int KEY_W       = 2 * WORD_W;
    localparam int KS_ROT      = 3;

    localparam logic [WORD_W-1:0] MAGIC_P = 32'hB7E1_5163;
    localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9E37_79B9;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_WORDS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MIX_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_MIX_A,
        ST_MIX_B,
        ST_CRYPT,
        ST_DONE
    } rc5_state_t;

    typedef enum logic [2:0] {
        OP_INIT,
        OP_ADD,
        OP_SUB,
        OP_ENC,
        OP_DEC,
        OP_KSA,
        OP_KSB
    } rc5_op_t;

endpackage

/* src/rc5_unit.sv */
// ============================================================================
// RC5 shared arithmetic unit
// One add/xor stage, one barrel rotator and one add/xor stage, selected by op.
// ============================================================================
module rc5_unit
    import rc5_pkg::*;
(
    input  rc5_op_t           op,
    input  logic [WORD_W-1:0] x,
    input  logic [WORD_W-1:0] y,
    input  logic [WORD_W-1:0] k,
    output logic [WORD_W-1:0] result
);

    localparam int SH_W = ROT_W + 1;

    logic [WORD_W-1:0] sum_xy;
    logic [WORD_W-1:0] pre;
    logic [WORD_W-1:0] rot;
    logic [ROT_W-1:0]  amt;

    assign sum_xy = x + y;

    always_comb
    begin
        pre = x;
        amt = '0;
        case (op)
            OP_INIT: pre = x + MAGIC_Q;
            OP_ADD:  pre = x + k;
            OP_SUB:  pre = x - k;
            OP_ENC:
            begin
                pre = x ^ y;
                amt = y[ROT_W-1:0];
            end
            OP_DEC:
            begin
                // right rotation as a left rotation by the negated amount
                pre = x - k;
                amt = ROT_W'(0) - y[ROT_W-1:0];
            end
            OP_KSA:
            begin
                pre = k + sum_xy;
                amt = ROT_W'(KS_ROT);
            end
            OP_KSB:
            begin
                pre = k + sum_xy;
                amt = sum_xy[ROT_W-1:0];
            end
            default:
            begin
                pre = x;
                amt = '0;
            end
        endcase
    end

    // a zero amount shifts the right half out entirely, leaving the word as is
    assign rot = (pre << amt) | (pre >> (SH_W'(WORD_W) - {1'b0, amt}));

    always_comb
    begin
        case (op)
            OP_ENC:  result = rot + k;
            OP_DEC:  result = rot ^ y;
            default: result = rot;
        endcase
    end

endmodule

/* src/rc5_block_cipher.sv */
// ============================================================================
// RC5-32/12/8 block cipher
// Encrypts or decrypts one 64-bit block per transfer with a 64-bit key.
// ============================================================================
// The key register takes key byte i in bits 8i+7..8i; a write marks the round
// key table stale. The next block transfer then first expands the table: it
// loads its 26 words from P and Q in ST_INIT, then runs 78 mixing steps, each
// an ST_MIX_A then an ST_MIX_B state. With a current table a block runs 26
// half-rounds (whitening words included) in ST_CRYPT on the single shared
// add/rotate/add unit, one table word read per cycle, and ST_DONE then loads
// the output register once it is free. Input ready returns in the cycle
// after that load. The input side is not ready while a block is in flight;
// a finished result waits in the output register, so the next block can be
// taken before it is collected.
// Write the key only while no block is in flight.
module rc5_block_cipher
    import rc5_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [KEY_W-1:0]  key,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [WORD_W-1:0] in_a,
    input  logic [WORD_W-1:0] in_b,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_a,
    output logic [WORD_W-1:0] out_b
);

    // control state
    rc5_state_t        state_reg, state_next;
    logic              sched_ready_reg, sched_ready_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // payload
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              op_reg, op_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] ks_a_reg, ks_a_next;
    logic [WORD_W-1:0] ks_b_reg, ks_b_next;
    logic [WORD_W-1:0] out_a_reg, out_a_next;
    logic [WORD_W-1:0] out_b_reg, out_b_next;
    logic [WORD_W-1:0] rk_reg [TABLE_WORDS];
    logic [WORD_W-1:0] kw_reg [2];

    // table write ports
    logic              rk_we;
    logic [WORD_W-1:0] rk_wdata;
    logic              kw_we;
    logic              kw_load;
    logic [WORD_W-1:0] rk_rdata;
    logic [WORD_W-1:0] kw_rdata;

    // shared unit
    rc5_op_t           unit_op;
    logic [WORD_W-1:0] unit_x;
    logic [WORD_W-1:0] unit_y;
    logic [WORD_W-1:0] unit_k;
    logic [WORD_W-1:0] unit_res;

    logic in_xfer;
    logic cfg_xfer;
    logic even_idx;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_a     = out_a_reg;
    assign out_b     = out_b_reg;

    assign in_xfer  = in_valid && in_ready;
    assign cfg_xfer = cfg_valid && cfg_ready;
    assign even_idx = ~idx_reg[0];

    // one table read port, addressed by the index in every phase
    assign rk_rdata = rk_reg[idx_reg];
    // key word alternates with each mixing step
    assign kw_rdata = kw_reg[step_reg[0]];

    rc5_unit u_unit (
        .op     (unit_op),
        .x      (unit_x),
        .y      (unit_y),
        .k      (unit_k),
        .result (unit_res)
    );

    always_comb
    begin
        state_next       = state_reg;
        sched_ready_next = sched_ready_reg;
        out_valid_next   = out_valid_reg;
        idx_next         = idx_reg;
        step_next        = step_reg;
        key_next         = key_reg;
        op_next          = op_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        ks_a_next        = ks_a_reg;
        ks_b_next        = ks_b_reg;
        out_a_next       = out_a_reg;
        out_b_next       = out_b_reg;
        rk_we            = 1'b0;
        rk_wdata         = unit_res;
        kw_we            = 1'b0;
        kw_load          = 1'b0;
        unit_op          = OP_INIT;
        unit_x           = ks_a_reg;
        unit_y           = ks_b_reg;
        unit_k           = rk_rdata;

        // drop the result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next = operation;
                    a_next  = in_a;
                    b_next  = in_b;
                    if (sched_ready_reg)
                    begin
                        state_next = ST_CRYPT;
                        idx_next   = operation ? LAST_IDX : '0;
                    end
                    else
                    begin
                        state_next = ST_INIT;
                        idx_next   = '0;
                        ks_a_next  = MAGIC_P;
                        kw_load    = 1'b1;
                    end
                end
            end

            ST_INIT:
            begin
                // store the running P + n*Q value, advance it by Q
                unit_op   = OP_INIT;
                unit_x    = ks_a_reg;
                rk_we     = 1'b1;
                rk_wdata  = ks_a_reg;
                ks_a_next = unit_res;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_MIX_A;
                    idx_next   = '0;
                    step_next  = '0;
                    ks_a_next  = '0;
                    ks_b_next  = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_MIX_A:
            begin
                unit_op    = OP_KSA;
                unit_k     = rk_rdata;
                rk_we      = 1'b1;
                ks_a_next  = unit_res;
                state_next = ST_MIX_B;
            end

            ST_MIX_B:
            begin
                unit_op   = OP_KSB;
                unit_k    = kw_rdata;
                kw_we     = 1'b1;
                ks_b_next = unit_res;
                step_next = step_reg + 1'b1;
                idx_next  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    sched_ready_next = 1'b1;
                    state_next       = ST_CRYPT;
                    idx_next         = op_reg ? LAST_IDX : '0;
                end
                else
                begin
                    state_next = ST_MIX_A;
                end
            end

            ST_CRYPT:
            begin
                // even table words update A, odd ones update B
                unit_x = even_idx ? a_reg : b_reg;
                unit_y = even_idx ? b_reg : a_reg;
                unit_k = rk_rdata;
                if (idx_reg < IDX_W'(2))
                begin
                    unit_op = op_reg ? OP_SUB : OP_ADD;
                end
                else
                begin
                    unit_op = op_reg ? OP_DEC : OP_ENC;
                end
                if (even_idx)
                begin
                    a_next = unit_res;
                end
                else
                begin
                    b_next = unit_res;
                end
                if (op_reg ? (idx_reg == '0) : (idx_reg == LAST_IDX))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = op_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_a_next     = a_reg;
                    out_b_next     = b_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a key write marks the table stale
        if (cfg_xfer)
        begin
            key_next         = key;
            sched_ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sched_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            idx_reg         <= '0;
            step_reg        <= '0;
            key_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            sched_ready_reg <= sched_ready_next;
            out_valid_reg   <= out_valid_next;
            idx_reg         <= idx_next;
            step_reg        <= step_next;
            key_reg         <= key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        ks_a_reg  <= ks_a_next;
        ks_b_reg  <= ks_b_next;
        out_a_reg <= out_a_next;
        out_b_reg <= out_b_next;
        if (rk_we)
        begin
            rk_reg[idx_reg] <= rk_wdata;
        end
        if (kw_load)
        begin
            kw_reg[0] <= key_reg[WORD_W-1:0];
            kw_reg[1] <= key_reg[KEY_W-1:WORD_W];
        end
        else if (kw_we)
        begin
            kw_reg[step_reg[0]] <= unit_res;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_crypt_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CRYPT) |-> sched_ready_reg)
        else $error("block processed with a stale round key table");

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input ready right after a block transfer");

    a_key_write_stales: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_xfer && state_reg == ST_IDLE) |=> !sched_ready_reg)
        else $error("key write did not mark the table stale");

    a_schedule_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX_B && step_reg == LAST_STEP && !cfg_xfer)
        |=> (sched_ready_reg && state_reg == ST_CRYPT))
        else $error("last mixing step did not complete the schedule");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("table index out of range");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC5-32/12/8 block cipher bench
// Streams encrypt and decrypt transfers through the cipher under a series of
// keys and checks every output block against a bit-exact cipher model.
// ----------------------------------------------------------------------------
module tb;
    import rc5_pkg::*;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Longest no-transfer stretch: long output hold, a schedule rebuild and a
    // block, plus sender gaps; the watchdog allows several times that.
    localparam int LONG_HOLD   = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 60;
    localparam int SHOW_MAX    = 10;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } block_t;

    typedef struct packed {
        logic   mode;
        block_t blk;
    } job_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [KEY_W-1:0]  key       = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              operation = MODE_ENCRYPT;
    logic [WORD_W-1:0] in_a      = '0;
    logic [WORD_W-1:0] in_b      = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [WORD_W-1:0] out_a;
    logic [WORD_W-1:0] out_b;

    rc5_block_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .key       (key),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .in_a      (in_a),
        .in_b      (in_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_a     (out_a),
        .out_b     (out_b)
    );

    // Round key table of the cipher model, rebuilt on every key transfer.
    logic [WORD_W-1:0] round_key [TABLE_WORDS];

    job_t   pending_jobs[$];   // blocks waiting to be offered
    block_t expected_out[$];   // predicted output blocks, oldest first

    bit in_taken;              // input transfer at the last rising edge
    bit idle_on;               // random gaps on both sides enabled
    int hold_requests;         // long output holds asked for
    int holds_done;            // long output holds completed
    int hold_left;
    int tx_gap;
    int rx_gap;
    int quiet_cycles;
    int fail_count;
    int enc_count;
    int dec_count;
    int checked_count;
    int key_loads;

    // ------------------------------------------------------------------------
    // Cipher model
    // ------------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input logic [ROT_W-1:0] s);
        logic [2*WORD_W-1:0] d;
        d = {x, x} << s;
        return d[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input logic [ROT_W-1:0] s);
        logic [2*WORD_W-1:0] d;
        d = {x, x} >> s;
        return d[WORD_W-1:0];
    endfunction

    function automatic void expand_schedule(input logic [KEY_W-1:0] k);
        logic [WORD_W-1:0] kw [2];
        logic [WORD_W-1:0] sa;
        logic [WORD_W-1:0] sb;
        logic [WORD_W-1:0] amt;
        int i;
        int j;
        kw[0] = k[WORD_W-1:0];
        kw[1] = k[KEY_W-1:WORD_W];
        round_key[0] = MAGIC_P;
        for (int n = 1; n < TABLE_WORDS; n++)
            round_key[n] = round_key[n-1] + MAGIC_Q;
        sa = '0;
        sb = '0;
        i  = 0;
        j  = 0;
        for (int n = 0; n < MIX_STEPS; n++)
        begin
            round_key[i] = rotl(round_key[i] + sa + sb, ROT_W'(KS_ROT));
            sa    = round_key[i];
            amt   = sa + sb;
            kw[j] = rotl(kw[j] + sa + sb, amt[ROT_W-1:0]);
            sb    = kw[j];
            i     = (i + 1) % TABLE_WORDS;
            j     = j ^ 1;
        end
    endfunction

    function automatic block_t cipher_model(input logic mode, input block_t blk);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        block_t res;
        a = blk.a;
        b = blk.b;
        if (mode == MODE_ENCRYPT)
        begin
            a += round_key[0];
            b += round_key[1];
            for (int r = 1; r <= ROUNDS; r++)
            begin
                a = rotl(a ^ b, b[ROT_W-1:0]) + round_key[2*r];
                b = rotl(b ^ a, a[ROT_W-1:0]) + round_key[2*r+1];
            end
        end
        else
        begin
            for (int r = ROUNDS; r > 0; r--)
            begin
                b = rotr(b - round_key[2*r+1], a[ROT_W-1:0]) ^ a;
                a = rotr(a - round_key[2*r], b[ROT_W-1:0]) ^ b;
            end
            b -= round_key[1];
            a -= round_key[0];
        end
        res.a = a;
        res.b = b;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [WORD_W-1:0] corner_word();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return 32'h0000_0001;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= SHOW_MAX)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Input driver: change the payload at the falling edge. Hold valid and the
    // payload until the transfer, then insert a random gap or load the next
    // pending block. in_valid gets at most one assignment per edge.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        job_t job;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end
        else if (!in_valid || in_taken)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_jobs.size() > 0)
            begin
                job = pending_jobs.pop_front();
                operation <= job.mode;
                in_a      <= job.blk.a;
                in_b      <= job.blk.b;
                in_valid  <= 1'b1;
                tx_gap = idle_on ? pick_gap() : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Output receiver: a long hold, when asked for, takes precedence over the
    // random ready gaps. The hold is counted here so the sender keeps offering
    // blocks and the cipher backs up into its input.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap    = 0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            if (hold_left == 0)
                holds_done++;
            out_ready <= 1'b0;
        end
        else if (holds_done != hold_requests)
        begin
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            rx_gap = idle_on ? pick_gap() : 0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample every channel at the rising edge. A key transfer rebuilds
    // the model's table; an input transfer queues its predicted block; an
    // output transfer is checked field by field against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        block_t want;
        in_taken = rst_n && in_valid && in_ready;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            expand_schedule(key);
            key_loads++;
        end
        if (in_taken)
        begin
            expected_out.push_back(cipher_model(operation, '{a: in_a, b: in_b}));
            if (operation == MODE_ENCRYPT)
                enc_count++;
            else
                dec_count++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_out.size() == 0)
                note_failure($sformatf("unexpected output a=%h b=%h", out_a, out_b));
            else
            begin
                want = expected_out.pop_front();
                checked_count++;
                if (out_a !== want.a)
                    note_failure($sformatf("out_a: expected %h, got %h", want.a, out_a));
                if (out_b !== want.b)
                    note_failure($sformatf("out_b: expected %h, got %h", want.b, out_b));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transfer happens for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready)
            || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d blocks outstanding",
                     quiet_cycles, expected_out.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------------

    // Block until every queued block has gone in and come back out; a block
    // still on offer counts as queued.
    task automatic wait_drained();
        while (pending_jobs.size() != 0 || in_valid || expected_out.size() != 0)
            @(posedge clk);
    endtask

    // Write the key only with the cipher idle.
    task automatic load_key(input logic [KEY_W-1:0] k);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        key       <= k;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_job(input logic mode, input logic [WORD_W-1:0] a,
                            input logic [WORD_W-1:0] b);
        job_t job;
        job.mode  = mode;
        job.blk.a = a;
        job.blk.b = b;
        pending_jobs.push_back(job);
    endtask

    // Mix of fresh encryptions and decryptions, round trips that decrypt a
    // ciphertext under the current key, and blocks built from corner words.
    task automatic queue_random(input int count);
        block_t pt;
        block_t ct;
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 35)
                push_job(MODE_ENCRYPT, $urandom, $urandom);
            else if (r < 65)
                push_job(MODE_DECRYPT, $urandom, $urandom);
            else if (r < 85)
            begin
                pt.a = $urandom;
                pt.b = $urandom;
                ct = cipher_model(MODE_ENCRYPT, pt);
                push_job(MODE_DECRYPT, ct.a, ct.b);
            end
            else
                push_job(logic'($urandom_range(1)), corner_word(), corner_word());
        end
    endtask

    initial
    begin
        block_t ct;
        logic [KEY_W-1:0] key_plan [10];
        idle_on       = 1'b0;
        hold_requests = 0;

        key_plan[0] = '0;
        key_plan[1] = '1;
        key_plan[2] = {$urandom, $urandom};
        key_plan[3] = 64'h0706_0504_0302_0100;
        key_plan[4] = 64'h0000_0000_0000_0001;
        key_plan[5] = 64'h8000_0000_0000_0000;
        key_plan[6] = {$urandom, $urandom};
        key_plan[7] = 64'hFFFF_FFFF_0000_0000;
        key_plan[8] = {$urandom, $urandom};
        key_plan[9] = {$urandom, $urandom};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed blocks under the all-zero key, back to back: word extremes,
        // single set bits, both directions, and a round trip.
        load_key(key_plan[0]);
        push_job(MODE_ENCRYPT, '0, '0);
        push_job(MODE_DECRYPT, '0, '0);
        push_job(MODE_ENCRYPT, '1, '1);
        push_job(MODE_DECRYPT, '1, '1);
        push_job(MODE_ENCRYPT, '0, '1);
        push_job(MODE_ENCRYPT, '1, '0);
        push_job(MODE_ENCRYPT, 32'h0000_0001, '0);
        push_job(MODE_ENCRYPT, '0, 32'h0000_0001);
        push_job(MODE_DECRYPT, 32'h8000_0000, 32'h8000_0000);
        push_job(MODE_DECRYPT, 32'h0000_0020, 32'h0000_0040);
        push_job(MODE_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
        push_job(MODE_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
        ct = cipher_model(MODE_ENCRYPT, '{a: 32'h0123_4567, b: 32'h89AB_CDEF});
        push_job(MODE_DECRYPT, ct.a, ct.b);
        wait_drained();

        for (int p = 0; p < 10; p++)
        begin
            // Phases 0 and 4 run without any idling on either side.
            idle_on = !(p == 0 || p == 4);
            if (p == 6)
                load_key({$urandom, $urandom});  // overwritten before any block
            if (p > 0)
                load_key(key_plan[p]);
            case (p)
                3:
                begin
                    // Stall the output while the sender keeps offering.
                    queue_random(130);
                    hold_requests++;
                end
                5:
                begin
                    // Sender pauses until everything has come back.
                    queue_random(65);
                    wait_drained();
                    queue_random(65);
                end
                default: queue_random(130);
            endcase
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_out.size() != 0)
            $display("ERROR: %0d blocks never came out", expected_out.size());

        $display("checked %0d output blocks (%0d encrypt, %0d decrypt) under %0d key loads,",
                 checked_count, enc_count, dec_count, key_loads);
        $display("with random gaps, gap-free phases, a long output hold and a drain pause");
        if (fail_count == 0 && expected_out.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
